FILE: rtl/core/pitagg_pkg.sv
// Shared types and constants for the pending-interest entry core.
// Used by the front, queue, back and top level; depends on nothing.
package pitagg_pkg;

    // Connection id space and the usable limit on ids
    localparam int ID_SPACE  = 16;
    localparam int ID_W      = 4;
    localparam int MAX_CONNS = 16;
    localparam int HELD_W    = 5;
    localparam int TIME_W    = 32;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        V_FORWARD   = 2'd0,
        V_AGGREGATE = 2'd1,
        V_SATISFY   = 2'd2
    } verdict_t;

    typedef enum logic {
        K_INTEREST = 1'b0,
        K_DATA     = 1'b1
    } kind_t;

    // One command for the back end: either a single result, or a
    // mask of reverse routes that is sent out one result per bit.
    typedef struct packed {
        logic                multi;
        verdict_t            verdict;
        logic [HELD_W-1:0]   held;
        logic [ID_SPACE-1:0] mask;
    } cmd_t;

    // Queue fill status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Number of set bits in a route map
    function automatic logic [HELD_W-1:0] pop_count(input logic [ID_SPACE-1:0] m);
        logic [HELD_W-1:0] n;
        n = '0;
        for (int i = 0; i < ID_SPACE; i++)
        begin
            n = n + HELD_W'(m[i]);
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/pitagg_front.sv
// Front end: accepts requests, holds the entry state and classifies each request.
// Pushes one command per request into the queue. Depends on pitagg_pkg.
module pitagg_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       kind,
    input  logic [pitagg_pkg::ID_W-1:0]   conn_id,
    input  logic [pitagg_pkg::TIME_W-1:0] new_expiry,
    input  logic [pitagg_pkg::TIME_W-1:0] now,
    input  logic                       q_full,
    output logic                       push,
    output pitagg_pkg::cmd_t           push_cmd
);
    import pitagg_pkg::*;

    logic [ID_SPACE-1:0] route_map_reg, route_map_next;
    logic [TIME_W-1:0]   expiry_reg, expiry_next;

    logic                usable;
    logic [ID_SPACE-1:0] conn_bit;
    logic                expired;
    logic [ID_SPACE-1:0] map_c;
    logic [TIME_W-1:0]   exp_c;
    logic [ID_SPACE-1:0] send;

    assign push = in_valid && !q_full;

    // Decode the arriving connection
    assign usable   = (int'(conn_id) < MAX_CONNS);
    assign conn_bit = usable ? (ID_SPACE'(1) << conn_id) : '0;
    assign expired  = (expiry_reg <= now);
    assign map_c    = expired ? '0 : route_map_reg;
    assign exp_c    = expired ? '0 : expiry_reg;
    assign send     = route_map_reg & ~conn_bit;

    // Classify and compute the next entry state
    always_comb
    begin
        route_map_next   = route_map_reg;
        expiry_next      = expiry_reg;
        push_cmd.multi   = 1'b0;
        push_cmd.verdict = V_FORWARD;
        push_cmd.held    = '0;
        push_cmd.mask    = '0;
        if (kind == K_INTEREST)
        begin
            expiry_next    = (exp_c < new_expiry) ? new_expiry : exp_c;
            route_map_next = map_c;
            if (map_c == '0)
            begin
                route_map_next = conn_bit;
            end
            else if (((map_c & conn_bit) == '0) && usable)
            begin
                route_map_next   = map_c | conn_bit;
                push_cmd.verdict = V_AGGREGATE;
            end
            // an unexpired entry stays unexpired; a cleared one takes new_expiry
            if (expired && (new_expiry <= now))
                push_cmd.held = '0;
            else
                push_cmd.held = pop_count(route_map_next);
        end
        else
        begin
            push_cmd.verdict = V_SATISFY;
            if (!expired)
            begin
                route_map_next = '0;
                push_cmd.multi = (send != '0);
                push_cmd.mask  = send;
            end
        end
    end

    // Entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_map_reg <= '0;
            expiry_reg    <= '0;
        end
        else if (push)
        begin
            route_map_reg <= route_map_next;
            expiry_reg    <= expiry_next;
        end
    end

endmodule

FILE: rtl/core/pitagg_queue.sv
// Short command queue that decouples the front end from the back end.
// Register-based FIFO of cmd_t entries. Depends on pitagg_pkg.
module pitagg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pitagg_pkg::cmd_t      push_cmd,
    input  logic                  pop,
    output pitagg_pkg::cmd_t      head_cmd,
    output pitagg_pkg::q_status_t q_stat
);
    import pitagg_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // Overflow and underflow checks
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push || pop)
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("queue popped while empty");

endmodule

FILE: rtl/core/pitagg_back.sv
// Back end: takes commands from the queue and drives the result channel. A satisfy
// mask is sent one route per unstalled cycle, lowest id first. Depends on pitagg_pkg.
module pitagg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pitagg_pkg::cmd_t            head_cmd,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  verdict,
    output logic                        route_valid,
    output logic [pitagg_pkg::ID_W-1:0]   route_conn,
    output logic [pitagg_pkg::HELD_W-1:0] routes_held,
    output logic                        last
);
    import pitagg_pkg::*;

    cmd_t                cur_reg;
    logic                busy_reg;
    logic [ID_SPACE-1:0] rest;
    logic                is_last;
    logic                fire;
    logic                take;
    logic [ID_W-1:0]     low_id;

    assign rest    = cur_reg.mask & (cur_reg.mask - ID_SPACE'(1));
    assign is_last = !cur_reg.multi || (rest == '0);
    assign fire    = busy_reg && !out_stall;
    assign take    = !busy_reg || (fire && is_last);
    assign pop     = take && !q_empty;

    // Lowest held route
    always_comb
    begin
        low_id = '0;
        for (int i = ID_SPACE - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
                low_id = ID_W'(i);
        end
    end

    // Result fields straight from the working register
    assign out_valid   = busy_reg;
    assign verdict     = cur_reg.verdict;
    assign route_valid = cur_reg.multi;
    assign route_conn  = cur_reg.multi ? low_id : '0;
    assign routes_held = cur_reg.held;
    assign last        = is_last;

    // Working command
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_cmd;
        else if (fire && !is_last)
            cur_reg.mask <= rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (pop)
            busy_reg <= 1'b1;
        else if (fire && is_last)
            busy_reg <= 1'b0;
    end

    // A route result carries the satisfy verdict and no held count
    a_route_is_satisfy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && route_valid |-> verdict == V_SATISFY && routes_held == '0)
        else $error("route result without satisfy verdict");
    // A non-final route is followed by another result of the same request
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last |=> out_valid && route_valid)
        else $error("satisfy burst broke off before its last route");
    // A new command is only loaded once the current one is finished
    a_pop_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop && busy_reg |-> fire && last)
        else $error("command overwritten before its last result");

endmodule

FILE: rtl/core/pit_entry_interest_aggregation_core.sv
// Top level of the pending-interest entry core with interest aggregation.
// Instantiates pitagg_front, pitagg_queue and pitagg_back; depends on pitagg_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   request  | in_valid / in_stall   | kind, conn_id, new_expiry, now
//   result   | out_valid / out_stall | verdict, route_valid, route_conn,
//            |                       | routes_held, last
//
// An interest gives one result; its command is registered in the queue, then in the back end.
// A data request gives one result per route sent, at one per cycle from the back
// end while out_stall is low, or a single result when nothing is sent.
// The two-entry command queue lets requests be taken while results wait.
// Reset clears the route map and expiry (entry expired) and empties the queue.
// in_stall is high only while the command queue is full.
module pit_entry_interest_aggregation_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [pitagg_pkg::ID_W-1:0]   conn_id,
    input  logic [pitagg_pkg::TIME_W-1:0] new_expiry,
    input  logic [pitagg_pkg::TIME_W-1:0] now,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  verdict,
    output logic                        route_valid,
    output logic [pitagg_pkg::ID_W-1:0]   route_conn,
    output logic [pitagg_pkg::HELD_W-1:0] routes_held,
    output logic                        last
);
    import pitagg_pkg::*;

    q_status_t q_stat;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head_cmd;

    assign in_stall = q_stat.full;

    pitagg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .conn_id    (conn_id),
        .new_expiry (new_expiry),
        .now        (now),
        .q_full     (q_stat.full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    pitagg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    pitagg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_empty     (q_stat.empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .route_valid (route_valid),
        .route_conn  (route_conn),
        .routes_held (routes_held),
        .last        (last)
    );

endmodule

FILE: dv/tb_pit_entry_interest_aggregation_core.sv
// Testbench for pit_entry_interest_aggregation_core: directed and random interest/data
// requests, with results checked in order against a predicted pending-interest entry.
// Depends on pitagg_pkg and the core RTL only.
`timescale 1ns / 1ps

import pitagg_pkg::*;

// One result as the core should give it
typedef struct packed {
    verdict_t            verdict;
    logic                route_valid;
    logic [ID_W-1:0]     route_conn;
    logic [HELD_W-1:0]   held;
    logic                last;
} route_result_t;

// Predicted entry state plus the results still owed by the core
class pit_entry_scoreboard;
    logic [ID_SPACE-1:0] route_map;
    logic [TIME_W-1:0]   expiry_at;
    route_result_t       owed[$];
    int                  mismatches;

    function new();
        route_map  = '0;
        expiry_at  = '0;
        mismatches = 0;
    endfunction

    function int outstanding();
        return owed.size();
    endfunction

    function void owe(verdict_t v, logic rv, logic [ID_W-1:0] rc, logic [HELD_W-1:0] rh,
                      logic l);
        route_result_t r;
        r.verdict     = v;
        r.route_valid = rv;
        r.route_conn  = rc;
        r.held        = rh;
        r.last        = l;
        owed.push_back(r);
    endfunction

    // Update the entry for one accepted request and queue what it should emit
    function void note_request(kind_t k, logic [ID_W-1:0] c, logic [TIME_W-1:0] nexp,
                               logic [TIME_W-1:0] t);
        logic                usable;
        logic [ID_SPACE-1:0] mask;
        logic [ID_SPACE-1:0] send;
        verdict_t            v;
        logic [HELD_W-1:0]   held;
        usable = (int'(c) < MAX_CONNS);
        mask   = '0;
        if (usable)
        begin
            mask[c] = 1'b1;
        end
        if (k == K_INTEREST)
        begin
            v = V_FORWARD;
            // stale entry starts over before the expiry raise
            if (expiry_at <= t)
            begin
                route_map = '0;
                expiry_at = '0;
            end
            if (expiry_at < nexp)
            begin
                expiry_at = nexp;
            end
            if (route_map == '0)
            begin
                route_map = route_map | mask;
            end
            else if ((route_map & mask) == '0 && usable)
            begin
                route_map = route_map | mask;
                v = V_AGGREGATE;
            end
            held = '0;
            if (expiry_at > t)
            begin
                for (int i = 0; i < ID_SPACE; i++)
                begin
                    held = held + HELD_W'(route_map[i]);
                end
            end
            owe(v, 1'b0, '0, held, 1'b1);
        end
        else if (expiry_at <= t)
        begin
            // data on an expired entry: set is kept, nothing sent
            owe(V_SATISFY, 1'b0, '0, '0, 1'b1);
        end
        else
        begin
            send      = route_map & ~mask;
            route_map = '0;
            if (send == '0)
            begin
                owe(V_SATISFY, 1'b0, '0, '0, 1'b1);
            end
            else
            begin
                // one result per route, ascending id, last on the top one
                for (int i = 0; i < ID_SPACE; i++)
                begin
                    if (send[i])
                    begin
                        owe(V_SATISFY, 1'b1, ID_W'(i), '0, (send >> (i + 1)) == '0);
                    end
                end
            end
        end
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(logic [1:0] v, logic rv, logic [ID_W-1:0] rc,
                               logic [HELD_W-1:0] rh, logic l);
        route_result_t want;
        if (owed.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result: verdict=%0d valid=%0d conn=%0d held=%0d last=%0d",
                         v, rv, rc, rh, l);
            end
            return;
        end
        want = owed.pop_front();
        if (v !== want.verdict || rv !== want.route_valid || rc !== want.route_conn ||
            rh !== want.held || l !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result mismatch: exp verdict=%0d valid=%0d conn=%0d held=%0d last=%0d",
                         want.verdict, want.route_valid, want.route_conn, want.held,
                         want.last);
                $display("                 got verdict=%0d valid=%0d conn=%0d held=%0d last=%0d",
                         v, rv, rc, rh, l);
            end
        end
    endfunction
endclass

module tb_pit_entry_interest_aggregation_core;

    localparam int STUCK_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 170;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [ID_W-1:0]     conn_id;
    logic [TIME_W-1:0]   new_expiry;
    logic [TIME_W-1:0]   now;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          verdict;
    logic                route_valid;
    logic [ID_W-1:0]     route_conn;
    logic [HELD_W-1:0]   routes_held;
    logic                last;

    pit_entry_scoreboard sb;
    int                  send_idle;
    int                  recv_idle;
    int                  requests_sent;
    int                  stuck_cycles;

    pit_entry_interest_aggregation_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .conn_id     (conn_id),
        .new_expiry  (new_expiry),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .route_valid (route_valid),
        .route_conn  (route_conn),
        .routes_held (routes_held),
        .last        (last)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(verdict, route_valid, route_conn, routes_held, last);
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Present one request after a random gap and hold it until taken
    task automatic drive_request(input kind_t k, input logic [ID_W-1:0] c,
                                 input logic [TIME_W-1:0] nexp, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        conn_id    <= c;
        new_expiry <= nexp;
        now        <= t;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(k, c, nexp, t);
        requests_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every owed result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Edge cases: boundaries of expiry, retransmission, empty and full sets
    task automatic directed_requests();
        drive_request(K_INTEREST, 4'd0, 32'd0, 32'd0);
        drive_request(K_INTEREST, 4'd0, 32'd100, 32'd10);
        drive_request(K_INTEREST, 4'd15, 32'd50, 32'd12);
        drive_request(K_INTEREST, 4'd7, 32'hFFFF_FFFF, 32'd13);
        drive_request(K_DATA, 4'd7, 32'd0, 32'd20);
        drive_request(K_DATA, 4'd3, 32'hFFFF_FFFF, 32'd21);
        drive_request(K_INTEREST, 4'd5, 32'd0, 32'd22);
        drive_request(K_DATA, 4'd5, 32'd0, 32'd23);
        for (int i = 0; i < ID_SPACE; i++)
        begin
            drive_request(K_INTEREST, ID_W'(i), 32'd0, 32'd24);
        end
        drive_request(K_DATA, 4'd3, 32'd0, 32'hFFFF_FFFF);
        drive_request(K_INTEREST, 4'd3, 32'd0, 32'd1);
        drive_request(K_DATA, 4'd3, 32'd0, 32'd2);
        drive_request(K_INTEREST, 4'd9, 32'd10, 32'hFFFF_FFFF);
    endtask

    // A burst of interests from a small pool of connections, then data
    task automatic interest_burst_then_data();
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] nexp;
        logic [ID_W-1:0]   pool;
        logic [ID_W-1:0]   c;
        int                n;
        int                sel;
        t    = ($urandom_range(1) == 1) ? sb.expiry_at : $urandom;
        pool = ID_W'($urandom_range(15));
        n    = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            c    = pool + ID_W'($urandom_range(5));
            nexp = ($urandom_range(9) == 0) ? t - $urandom_range(1, 20)
                                            : t + $urandom_range(5, 60);
            drive_request(K_INTEREST, c, nexp, t + i);
        end
        sel = $urandom_range(9);
        c   = ($urandom_range(2) == 0) ? ID_W'($urandom) : pool + ID_W'($urandom_range(5));
        if (sel < 6)
        begin
            drive_request(K_DATA, c, $urandom, t + n + $urandom_range(3));
        end
        else if (sel < 8)
        begin
            drive_request(K_DATA, c, $urandom, sb.expiry_at);
        end
        else
        begin
            drive_request(K_DATA, c, $urandom, sb.expiry_at - 1);
        end
    endtask

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = K_INTEREST;
        conn_id       = '0;
        new_expiry    = '0;
        now           = '0;
        out_stall     = 1'b0;
        send_idle     = 26;
        recv_idle     = 80;
        requests_sent = 0;
        stuck_cycles  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_requests();

        // Three idle profiles: slow receiver, slow sender, none
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 26 : (phase == 1) ? 80 : 0;
            recv_idle = (phase == 0) ? 80 : (phase == 1) ? 26 : 0;
            while (requests_sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(4) == 0)
                begin
                    drive_request(kind_t'($urandom_range(1)), ID_W'($urandom), $urandom,
                                  $urandom);
                end
                else
                begin
                    interest_burst_then_data();
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pitagg_pkg.sv
rtl/core/pitagg_front.sv
rtl/core/pitagg_queue.sv
rtl/core/pitagg_back.sv
rtl/core/pit_entry_interest_aggregation_core.sv
dv/tb_pit_entry_interest_aggregation_core.sv
